[sv/obuf_pkg.sv]
// Shared types and constants for the OBU access unit framer.
package obuf_pkg;

  localparam int MAX_SIZE_BYTES  = 8;
  localparam int UNIT_COUNT_BITS = 32;
  localparam int SIZE_IDX_BITS   = 4;
  localparam int PAYLOAD_BITS    = 56;

  localparam logic [3:0] OBU_TD           = 4'd2;
  localparam logic [3:0] OBU_FRAME_HEADER = 4'd3;
  localparam logic [3:0] OBU_TILE_GROUP   = 4'd4;
  localparam logic [3:0] OBU_FRAME        = 4'd6;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RESERVED = 3'd2,
    ST_NOSIZE   = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_EXT     = 4'b0010,
    PH_SIZE    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic [3:0]  obu_kind;
    logic        obu_first;
    logic        obu_last;
    logic        au_first;
    logic        au_closed;
    logic [31:0] au_size;
    status_t     status;
  } res_t;

endpackage

[sv/obuf_parser.sv]
// OBU parsing state and the per-byte framing logic.
module obuf_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          end_of_source,
  output obuf_pkg::res_t res
);
  import obuf_pkg::*;

  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 header_r, header_nxt;
  logic [SIZE_IDX_BITS-1:0]   size_idx_r, size_idx_nxt;
  logic [PAYLOAD_BITS-1:0]    left_r, left_nxt;
  logic                       frame_seen_r, frame_seen_nxt;
  logic                       unit_open_r, unit_open_nxt;
  logic [UNIT_COUNT_BITS-1:0] unit_bytes_r, unit_bytes_nxt;
  logic                       err_r, err_nxt;
  status_t                    err_code_r, err_code_nxt;

  logic [UNIT_COUNT_BITS-1:0] bytes_inc;
  logic [PAYLOAD_BITS-1:0]    left_or;
  logic [PAYLOAD_BITS-1:0]    left_dec;
  logic [SIZE_IDX_BITS-1:0]   idx_inc;
  logic [3:0]                 b_type;

  assign bytes_inc = (&unit_bytes_r) ? unit_bytes_r : unit_bytes_r + 1'b1;
  assign left_or   = left_r | (PAYLOAD_BITS'({data_byte[6:0]}) << (7 * size_idx_r[2:0]));
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;
  assign idx_inc   = size_idx_r + 1'b1;
  assign b_type    = data_byte[6:3];

  always_comb begin
    phase_nxt      = phase_r;
    header_nxt     = header_r;
    size_idx_nxt   = size_idx_r;
    left_nxt       = left_r;
    frame_seen_nxt = frame_seen_r;
    unit_open_nxt  = unit_open_r;
    unit_bytes_nxt = unit_bytes_r;
    err_nxt        = err_r;
    err_code_nxt   = err_code_r;
    res            = '0;
    res.status     = ST_OK;

    if (end_of_source) begin
      if (err_r) begin
        res.status = err_code_r;
      end else if (phase_r != PH_HEADER) begin
        res.status = ST_TRUNC;
      end else if (unit_open_r) begin
        res.au_closed = 1'b1;
        res.au_size   = 32'(unit_bytes_r);
      end else begin
        res.status = ST_EMPTY;
      end
      phase_nxt      = PH_HEADER;
      header_nxt     = '0;
      size_idx_nxt   = '0;
      left_nxt       = '0;
      frame_seen_nxt = 1'b0;
      unit_open_nxt  = 1'b0;
      unit_bytes_nxt = '0;
      err_nxt        = 1'b0;
      err_code_nxt   = ST_OK;
    end else if (err_r) begin
      res.byte_out = data_byte;
      res.status   = err_code_r;
    end else begin
      res.byte_out   = data_byte;
      res.byte_valid = 1'b1;
      res.obu_kind   = header_r[6:3];
      case (phase_r)
        PH_HEADER: begin
          if (data_byte[0] || !data_byte[1]) begin
            err_nxt        = 1'b1;
            err_code_nxt   = data_byte[0] ? ST_RESERVED : ST_NOSIZE;
            unit_open_nxt  = 1'b0;
            frame_seen_nxt = 1'b0;
            unit_bytes_nxt = '0;
            size_idx_nxt   = '0;
            left_nxt       = '0;
            res.byte_valid = 1'b0;
            res.obu_kind   = '0;
            res.status     = err_code_nxt;
          end else begin
            header_nxt    = data_byte;
            res.obu_kind  = b_type;
            res.obu_first = 1'b1;
            if (b_type == OBU_TD && frame_seen_r) begin
              res.au_closed  = 1'b1;
              res.au_size    = 32'(unit_bytes_r);
              res.au_first   = 1'b1;
              frame_seen_nxt = 1'b0;
              unit_bytes_nxt = UNIT_COUNT_BITS'(1);
            end else begin
              res.au_first   = !unit_open_r;
              unit_bytes_nxt = bytes_inc;
            end
            unit_open_nxt = 1'b1;
            if (b_type inside {OBU_FRAME_HEADER, OBU_TILE_GROUP, OBU_FRAME}) begin
              frame_seen_nxt = 1'b1;
            end
            size_idx_nxt = '0;
            left_nxt     = '0;
            phase_nxt    = data_byte[2] ? PH_EXT : PH_SIZE;
          end
        end
        PH_EXT: begin
          unit_bytes_nxt = bytes_inc;
          phase_nxt      = PH_SIZE;
        end
        PH_SIZE: begin
          unit_bytes_nxt = bytes_inc;
          left_nxt       = left_or;
          size_idx_nxt   = idx_inc;
          if (!data_byte[7] || idx_inc >= SIZE_IDX_BITS'(MAX_SIZE_BYTES)) begin
            if (left_or == '0) begin
              res.obu_last = 1'b1;
              phase_nxt    = PH_HEADER;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          unit_bytes_nxt = bytes_inc;
          left_nxt       = left_dec;
          if (left_dec == '0) begin
            res.obu_last = 1'b1;
            phase_nxt    = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      header_r     <= '0;
      size_idx_r   <= '0;
      left_r       <= '0;
      frame_seen_r <= 1'b0;
      unit_open_r  <= 1'b0;
      unit_bytes_r <= '0;
      err_r        <= 1'b0;
      err_code_r   <= ST_OK;
    end else if (step) begin
      phase_r      <= phase_nxt;
      header_r     <= header_nxt;
      size_idx_r   <= size_idx_nxt;
      left_r       <= left_nxt;
      frame_seen_r <= frame_seen_nxt;
      unit_open_r  <= unit_open_nxt;
      unit_bytes_r <= unit_bytes_nxt;
      err_r        <= err_nxt;
      err_code_r   <= err_code_nxt;
    end
  end

endmodule

[sv/obu_access_unit_framer_unit.sv]
// Top level of the OBU access unit framer: input register, parser and result register.
// Accepted transactions pass from the input register through the parser into the result register.
// Throughput: one transaction per cycle; the input and result registers advance together
// whenever the result register is empty or its transaction is taken in the same cycle.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// waiting for an OBU header with no access unit open and no error held.
module obu_access_unit_framer_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_source,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte_out,
  output logic                   out_byte_valid,
  output logic [3:0]             out_obu_kind,
  output logic                   out_obu_first,
  output logic                   out_obu_last,
  output logic                   out_au_first,
  output logic                   out_au_closed,
  output logic [31:0]            out_au_size,
  output obuf_pkg::status_t      out_status
);
  import obuf_pkg::*;

  logic       advance;
  logic       in_valid_r;
  logic [7:0] data_r;
  logic       eos_r;
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data_byte;
      eos_r  <= in_end_of_source;
    end
  end

  obuf_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_valid_r && advance),
    .data_byte     (data_r),
    .end_of_source (eos_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_out   = res_r.byte_out;
  assign out_byte_valid = res_r.byte_valid;
  assign out_obu_kind   = res_r.obu_kind;
  assign out_obu_first  = res_r.obu_first;
  assign out_obu_last   = res_r.obu_last;
  assign out_au_first   = res_r.au_first;
  assign out_au_closed  = res_r.au_closed;
  assign out_au_size    = res_r.au_size;
  assign out_status     = res_r.status;

  a_first_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_obu_first || out_obu_last || out_au_first)) |-> out_byte_valid)
    else $error("OBU flag set on a byte outside a well-formed OBU.");

  a_close_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_au_closed) |-> (out_status == ST_OK))
    else $error("Access unit closed with a non-ok status.");

  a_au_first_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_au_first) |-> out_obu_first)
    else $error("Access unit opened on a byte that is not an OBU header.");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_r)))
    else $error("Result register changed while its transaction was stalled.");

endmodule
